[hdl/damped_wave_grid_step_top_defines.svh]
`ifndef DAMPED_WAVE_GRID_STEP_TOP_DEFINES_SVH
`define DAMPED_WAVE_GRID_STEP_TOP_DEFINES_SVH
// ----------------------------------------------------------------------------
// Damped wave grid step: assertion macros
// Shared wrappers for the concurrent checks on the block boundary.
// ----------------------------------------------------------------------------

// The consequent must hold in the cycle after the antecedent matches.
`define DWG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle where the antecedent ends.
`define DWG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hdl/dwg_pkg.sv]
// ----------------------------------------------------------------------------
// Damped wave grid step: package
// Register indexes, fixed constants and the types shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dwg_pkg;

  localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ACCEL       = 3'd2;
  localparam logic [2:0] REG_DAMPING     = 3'd3;
  localparam logic [2:0] REG_TIME_STEP   = 3'd4;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam int unsigned MUL_CHUNK = 26;
  localparam int unsigned MUL_BW    = 26;

  typedef struct packed {
    logic [6:0]  grid_width;
    logic [6:0]  grid_height;
    logic [23:0] acceleration;
    logic [23:0] damping;
    logic [16:0] time_step;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
  } req_t;

  typedef struct packed {
    logic signed [31:0] cell_deflection;
    logic signed [31:0] cell_velocity;
    logic [47:0]        elapsed_time;
    logic               cell_valid;
  } result_t;

endpackage

`default_nettype wire

[hdl/dwg_regs.sv]
// ----------------------------------------------------------------------------
// Damped wave grid step: configuration registers
// APB register file holding the grid size and the physical coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module dwg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic [4:0]    paddr_i,
  input  logic [31:0]   pwdata_i,
  output logic [31:0]   prdata_o,
  output dwg_pkg::cfg_t cfg_o
);

  dwg_pkg::cfg_t cfg_q;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx   = paddr_i[4:2];
  assign wr_en = psel_i & penable_i & pwrite_i;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width   <= 7'd64;
      cfg_q.grid_height  <= 7'd64;
      cfg_q.acceleration <= 24'd65536;
      cfg_q.damping      <= 24'd0;
      cfg_q.time_step    <= 17'd6554;
    end else if (wr_en) begin
      case (idx)
        dwg_pkg::REG_GRID_WIDTH:  cfg_q.grid_width   <= pwdata_i[6:0];
        dwg_pkg::REG_GRID_HEIGHT: cfg_q.grid_height  <= pwdata_i[6:0];
        dwg_pkg::REG_ACCEL:       cfg_q.acceleration <= pwdata_i[23:0];
        dwg_pkg::REG_DAMPING:     cfg_q.damping      <= pwdata_i[23:0];
        dwg_pkg::REG_TIME_STEP:   cfg_q.time_step    <= pwdata_i[16:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      dwg_pkg::REG_GRID_WIDTH:  prdata_o = 32'(cfg_q.grid_width);
      dwg_pkg::REG_GRID_HEIGHT: prdata_o = 32'(cfg_q.grid_height);
      dwg_pkg::REG_ACCEL:       prdata_o = 32'(cfg_q.acceleration);
      dwg_pkg::REG_DAMPING:     prdata_o = 32'(cfg_q.damping);
      dwg_pkg::REG_TIME_STEP:   prdata_o = 32'(cfg_q.time_step);
      default:                  prdata_o = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/dwg_mulq.sv]
// ----------------------------------------------------------------------------
// Damped wave grid step: fixed-point multiplier
// Multi-cycle signed multiply by chunks of the first operand, followed by
// rounding to nearest with ties away from zero and a shift of 16 or 18.
// ----------------------------------------------------------------------------
`default_nettype none

module dwg_mulq #(
  parameter int unsigned AW = 35,
  parameter int unsigned RW = 63
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           sh18_i,
  input  logic signed [AW-1:0]           a_i,
  input  logic signed [dwg_pkg::MUL_BW-1:0] b_i,
  output logic                           done_o,
  output logic signed [RW-1:0]           res_o
);

  localparam int unsigned CH  = dwg_pkg::MUL_CHUNK;
  localparam int unsigned BW  = dwg_pkg::MUL_BW;
  localparam int unsigned NCH = (AW + CH - 1) / CH;
  localparam int unsigned MW  = NCH * CH;
  localparam int unsigned PW  = MW + BW;
  localparam int unsigned CB  = $clog2(NCH + 2);

  logic [MW-1:0]        ma_q;
  logic [BW-1:0]        mb_q;
  logic                 neg_q;
  logic                 sh18_q;
  logic                 busy_q;
  logic                 done_q;
  logic [CB-1:0]        cnt_q;
  logic [CH+BW-1:0]     pp_q;
  logic [PW-1:0]        acc_q;
  logic signed [RW-1:0] res_q;

  logic [AW-1:0]        ua;
  logic [BW-1:0]        ub;
  logic [AW-1:0]        ma_d;
  logic [BW-1:0]        mb_d;
  logic [PW:0]          rnd;
  logic [PW:0]          mag;
  logic [RW-1:0]        mag_r;

  assign ua   = a_i;
  assign ub   = b_i;
  assign ma_d = ua[AW-1] ? (~ua + AW'(1)) : ua;
  assign mb_d = ub[BW-1] ? (~ub + BW'(1)) : ub;
  assign rnd  = (PW+1)'(acc_q) + (sh18_q ? (PW+1)'(1 << 17) : (PW+1)'(1 << 15));
  assign mag  = sh18_q ? (rnd >> 18) : (rnd >> 16);
  assign mag_r = mag[RW-1:0];

  assign done_o = done_q;
  assign res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CB'(NCH + 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CB'(NCH + 1)) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + CB'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q   <= MW'(ma_d);
      mb_q   <= mb_d;
      neg_q  <= a_i[AW-1] ^ b_i[BW-1];
      sh18_q <= sh18_i;
      acc_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q < CB'(NCH)) begin
        pp_q <= ma_q[MW-1 -: CH] * mb_q;
        ma_q <= ma_q << CH;
      end
      if ((cnt_q != '0) && (cnt_q <= CB'(NCH))) begin
        acc_q <= (acc_q << CH) + PW'(pp_q);
      end
      if (cnt_q == CB'(NCH + 1)) begin
        res_q <= neg_q ? $signed(~mag_r + RW'(1)) : $signed(mag_r);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/dwg_engine.sv]
// ----------------------------------------------------------------------------
// Damped wave grid step: grid engine
// Holds both grids in block memories and sequences the two update sweeps,
// the cell report and the clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dwg_engine #(
  parameter int unsigned MAX_COLUMNS = 64,
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dwg_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dwg_pkg::req_t    in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dwg_pkg::result_t out_res_o
);

  localparam int unsigned VB    = VALUE_BITS;
  localparam int unsigned CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned IW    = $clog2(CELLS);
  localparam int unsigned XB    = $clog2(MAX_COLUMNS);
  localparam int unsigned YB    = $clog2(MAX_ROWS);
  localparam int unsigned WB    = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned HB    = $clog2(MAX_ROWS + 1);
  localparam int unsigned AW    = VB + 3;
  localparam int unsigned CH    = dwg_pkg::MUL_CHUNK;
  localparam int unsigned BW    = dwg_pkg::MUL_BW;
  localparam int unsigned NCH   = (AW + CH - 1) / CH;
  localparam int unsigned PW    = NCH * CH + BW;
  localparam int unsigned RW    = PW - 15;
  localparam int unsigned SW    = RW + 1;

  localparam logic [IW-1:0] ROW_STEP  = IW'(MAX_COLUMNS);
  localparam logic [IW-1:0] FIRST     = IW'(MAX_COLUMNS + 1);
  localparam logic [IW-1:0] LAST_CELL = IW'(CELLS - 1);

  localparam logic signed [SW-1:0] VMAX_S = (SW'(1) << (VB - 1)) - SW'(1);
  localparam logic signed [SW-1:0] VMIN_S = ~VMAX_S;
  localparam logic signed [SW-1:0] OMAX_S = SW'(32'h7fff_ffff);
  localparam logic signed [SW-1:0] OMIN_S = ~OMAX_S;

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_SETUP   = 4'd2;
  localparam logic [3:0] S_P1_RD   = 4'd3;
  localparam logic [3:0] S_P1_ST   = 4'd4;
  localparam logic [3:0] S_P1_WT   = 4'd5;
  localparam logic [3:0] S_P2_RD   = 4'd6;
  localparam logic [3:0] S_P2_W1   = 4'd7;
  localparam logic [3:0] S_P2_S2   = 4'd8;
  localparam logic [3:0] S_P2_W2   = 4'd9;
  localparam logic [3:0] S_RPT     = 4'd10;
  localparam logic [3:0] S_RPT_OUT = 4'd11;

  function automatic logic signed [VB-1:0] sat_v(input logic signed [SW-1:0] v);
    if (v > VMAX_S) begin
      sat_v = VMAX_S[VB-1:0];
    end else if (v < VMIN_S) begin
      sat_v = VMIN_S[VB-1:0];
    end else begin
      sat_v = v[VB-1:0];
    end
  endfunction

  function automatic logic signed [31:0] out32(input logic signed [VB-1:0] v);
    logic signed [SW-1:0] t;
    t = SW'(v);
    if (t > OMAX_S) begin
      out32 = OMAX_S[31:0];
    end else if (t < OMIN_S) begin
      out32 = OMIN_S[31:0];
    end else begin
      out32 = t[31:0];
    end
  endfunction

  logic signed [VB-1:0] defl_mem [CELLS];
  logic signed [VB-1:0] vel_mem [CELLS];
  logic signed [VB-1:0] defl_rdata_q;
  logic signed [VB-1:0] vel_rdata_q;

  logic                 defl_we, vel_we, defl_re, vel_re;
  logic [IW-1:0]        defl_waddr, vel_waddr, defl_raddr, vel_raddr;
  logic signed [VB-1:0] defl_wdata, vel_wdata;

  logic [3:0]    state_q;
  logic [IW-1:0] clr_q;
  logic [IW-1:0] idx_q;
  logic [XB-1:0] x_q;
  logic [YB-1:0] y_q;
  logic [2:0]    k_q;
  logic          out_valid_q;
  logic [47:0]   time_q;

  logic [WB-1:0]        w_q;
  logic [HB-1:0]        h_q;
  logic [IW-1:0]        rpt_idx_q;
  logic                 cv_q;
  logic [16:0]          dt_q;
  logic [24:0]          accf_q;
  logic signed [25:0]   dampf_q;
  logic signed [VB-1:0] d_q, v_q, v1_q;
  logic signed [AW-1:0] sum_q;
  dwg_pkg::result_t     out_q;

  logic [31:0]          gw32, gh32;
  logic [WB-1:0]        w_c;
  logic [HB-1:0]        h_c;
  logic [16:0]          dt_c;
  logic [40:0]          accp, dampp;
  logic [24:0]          accf_c, dampr;
  logic signed [25:0]   dampf_c;
  logic [IW-1:0]        rpt_idx_c;
  logic                 cv_c;
  logic                 last_x, last_y;
  logic [IW-1:0]        next_row;
  logic [IW-1:0]        nb_addr;
  logic                 accept;

  logic                 mul_start, mul_sh18, mul_done;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [RW-1:0] mul_res;

  assign gw32 = 32'(cfg_i.grid_width);
  assign gh32 = 32'(cfg_i.grid_height);
  assign w_c  = WB'((gw32 < 32'd3) ? 32'd3 : ((gw32 > MAX_COLUMNS) ? 32'(MAX_COLUMNS) : gw32));
  assign h_c  = HB'((gh32 < 32'd3) ? 32'd3 : ((gh32 > MAX_ROWS) ? 32'(MAX_ROWS) : gh32));

  assign dt_c    = (cfg_i.time_step > dwg_pkg::ONE_Q16) ? dwg_pkg::ONE_Q16 : cfg_i.time_step;
  assign accp    = 41'(cfg_i.acceleration) * 41'(dt_c);
  assign dampp   = 41'(cfg_i.damping) * 41'(dt_c);
  assign accf_c  = 25'((accp + 41'd32768) >> 16);
  assign dampr   = 25'((dampp + 41'd32768) >> 16);
  assign dampf_c = $signed(26'd65536 - 26'(dampr));

  assign rpt_idx_c = IW'(32'(in_req_i.cell_y) * MAX_COLUMNS + 32'(in_req_i.cell_x));
  assign cv_c      = (32'(in_req_i.cell_x) < 32'(w_c)) && (32'(in_req_i.cell_y) < 32'(h_c));

  assign last_x   = (x_q == XB'(w_q - WB'(2)));
  assign last_y   = (y_q == YB'(h_q - HB'(2)));
  assign next_row = idx_q + ROW_STEP - IW'(w_q) + IW'(3);

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_comb begin
    case (k_q)
      3'd0:    nb_addr = idx_q - IW'(1);
      3'd1:    nb_addr = idx_q + IW'(1);
      3'd2:    nb_addr = idx_q - ROW_STEP;
      3'd3:    nb_addr = idx_q + ROW_STEP;
      default: nb_addr = idx_q;
    endcase
  end

  always_comb begin
    defl_we    = 1'b0;
    vel_we     = 1'b0;
    defl_re    = 1'b0;
    vel_re     = 1'b0;
    defl_waddr = idx_q;
    vel_waddr  = idx_q;
    defl_raddr = idx_q;
    vel_raddr  = idx_q;
    defl_wdata = sat_v(SW'(d_q) + SW'(mul_res));
    vel_wdata  = sat_v(SW'(mul_res));
    case (state_q)
      S_CLR: begin
        defl_we    = 1'b1;
        vel_we     = 1'b1;
        defl_waddr = clr_q;
        vel_waddr  = clr_q;
        defl_wdata = (clr_q == FIRST) ? VB'(dwg_pkg::ONE_Q16) : '0;
        vel_wdata  = '0;
      end
      S_P1_RD: begin
        defl_re = 1'b1;
        vel_re  = 1'b1;
      end
      S_P1_WT: defl_we = mul_done;
      S_P2_RD: begin
        defl_re    = (k_q < 3'd5);
        defl_raddr = nb_addr;
        vel_re     = (k_q == 3'd0);
      end
      S_P2_W2: vel_we = mul_done;
      S_RPT: begin
        defl_re    = 1'b1;
        vel_re     = 1'b1;
        defl_raddr = rpt_idx_q;
        vel_raddr  = rpt_idx_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    mul_sh18  = 1'b0;
    mul_a     = AW'(vel_rdata_q);
    mul_b     = BW'(dt_q);
    case (state_q)
      S_P1_ST: mul_start = 1'b1;
      S_P2_RD: begin
        mul_start = (k_q == 3'd5);
        mul_sh18  = 1'b1;
        mul_a     = sum_q - (AW'(defl_rdata_q) <<< 2);
        mul_b     = BW'(accf_q);
      end
      S_P2_S2: begin
        mul_start = 1'b1;
        mul_a     = AW'(v1_q);
        mul_b     = BW'(dampf_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (defl_we) begin
      defl_mem[defl_waddr] <= defl_wdata;
    end
    if (defl_re) begin
      defl_rdata_q <= defl_mem[defl_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vel_we) begin
      vel_mem[vel_waddr] <= vel_wdata;
    end
    if (vel_re) begin
      vel_rdata_q <= vel_mem[vel_raddr];
    end
  end

  dwg_mulq #(
    .AW(AW),
    .RW(RW)
  ) u_mulq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .sh18_i  (mul_sh18),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      idx_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      time_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_RPT_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + IW'(1);
          if (clr_q == LAST_CELL) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_q <= in_req_i.kind ? S_RPT : S_SETUP;
          end
        end
        S_SETUP: begin
          x_q     <= XB'(1);
          y_q     <= YB'(1);
          idx_q   <= FIRST;
          state_q <= S_P1_RD;
        end
        S_P1_RD: state_q <= S_P1_ST;
        S_P1_ST: state_q <= S_P1_WT;
        S_P1_WT: begin
          if (mul_done) begin
            if (last_x && last_y) begin
              x_q     <= XB'(1);
              y_q     <= YB'(1);
              idx_q   <= FIRST;
              k_q     <= '0;
              state_q <= S_P2_RD;
            end else begin
              if (last_x) begin
                x_q   <= XB'(1);
                y_q   <= y_q + YB'(1);
                idx_q <= next_row;
              end else begin
                x_q   <= x_q + XB'(1);
                idx_q <= idx_q + IW'(1);
              end
              state_q <= S_P1_RD;
            end
          end
        end
        S_P2_RD: begin
          k_q <= k_q + 3'd1;
          if (k_q == 3'd5) begin
            state_q <= S_P2_W1;
          end
        end
        S_P2_W1: begin
          if (mul_done) begin
            state_q <= S_P2_S2;
          end
        end
        S_P2_S2: state_q <= S_P2_W2;
        S_P2_W2: begin
          if (mul_done) begin
            k_q <= '0;
            if (last_x && last_y) begin
              time_q  <= time_q + 48'(dt_q);
              state_q <= S_RPT;
            end else begin
              if (last_x) begin
                x_q   <= XB'(1);
                y_q   <= y_q + YB'(1);
                idx_q <= next_row;
              end else begin
                x_q   <= x_q + XB'(1);
                idx_q <= idx_q + IW'(1);
              end
              state_q <= S_P2_RD;
            end
          end
        end
        S_RPT: state_q <= S_RPT_OUT;
        S_RPT_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          w_q       <= w_c;
          h_q       <= h_c;
          rpt_idx_q <= rpt_idx_c;
          cv_q      <= cv_c;
        end
      end
      S_SETUP: begin
        dt_q    <= dt_c;
        accf_q  <= accf_c;
        dampf_q <= dampf_c;
      end
      S_P1_ST: d_q <= defl_rdata_q;
      S_P2_RD: begin
        if (k_q == 3'd0) begin
          sum_q <= '0;
        end else if (k_q < 3'd5) begin
          sum_q <= sum_q + AW'(defl_rdata_q);
        end
        if (k_q == 3'd1) begin
          v_q <= vel_rdata_q;
        end
      end
      S_P2_W1: begin
        if (mul_done) begin
          v1_q <= sat_v(SW'(v_q) + SW'(mul_res));
        end
      end
      S_RPT_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.cell_deflection <= cv_q ? out32(defl_rdata_q) : 32'sd0;
          out_q.cell_velocity   <= cv_q ? out32(vel_rdata_q) : 32'sd0;
          out_q.elapsed_time    <= time_q;
          out_q.cell_valid      <= cv_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/damped_wave_grid_step_top.sv]
// ----------------------------------------------------------------------------
// Damped wave grid step: top level
// Stream request and result ports around the grid engine, plus the APB
// configuration registers.
// ----------------------------------------------------------------------------
// After reset the block clears both grids, one cell per cycle, over all
// MAX_COLUMNS*MAX_ROWS cells (4096 by default) before it takes a request.
// A read-only request reads its cell in S_RPT and registers the result
// in S_RPT_OUT once the output register is free. A step request sweeps
// the interior cells twice through the single read port of each grid
// memory and one shared multi-cycle multiplier, which splits its
// VALUE_BITS+3 bit first operand into 26-bit chunks (two by default).
// Requests are taken one at a time; a finished result waits in an output
// register while the next request is taken.
`default_nettype none

module damped_wave_grid_step_top #(
  parameter int unsigned MAX_COLUMNS = 64,
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [15:0]   s_axis_tdata,   // cell_x, cell_y, zero fill
  input  logic [0:0]    s_axis_tuser,   // kind
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [111:0]  m_axis_tdata,   // cell_deflection, cell_velocity, elapsed_time
  output logic [0:0]    m_axis_tuser,   // cell_valid
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  dwg_pkg::cfg_t    cfg;
  dwg_pkg::req_t    req;
  dwg_pkg::result_t res;

  assign pready      = 1'b1;
  assign req.kind    = s_axis_tuser[0];
  assign req.cell_x  = s_axis_tdata[5:0];
  assign req.cell_y  = s_axis_tdata[11:6];

  assign m_axis_tdata = {res.elapsed_time, res.cell_velocity, res.cell_deflection};
  assign m_axis_tuser = res.cell_valid;

  dwg_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  dwg_engine #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (req),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

endmodule

`default_nettype wire

[hdl/dwg_checker.sv]
// ----------------------------------------------------------------------------
// Damped wave grid step: port checker
// Concurrent checks on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "damped_wave_grid_step_top_defines.svh"

module dwg_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser,
  input logic         psel,
  input logic         penable,
  input logic         pwrite,
  input logic [4:0]   paddr,
  input logic [31:0]  pwdata,
  input logic [31:0]  prdata,
  input logic         pready
);

  logic width_wr;

  assign width_wr = psel && penable && pwrite && pready
                    && (paddr[4:2] == dwg_pkg::REG_GRID_WIDTH);

  `DWG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  `DWG_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `DWG_ASSERT_NEXT(a_one_req, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while one is in work")
  `DWG_ASSERT_NOW(a_readback, clk_i, rst_ni, (width_wr) ##1 (paddr == $past(paddr)), prdata[6:0] == $past(pwdata[6:0]), "grid width readback mismatch")

endmodule

bind damped_wave_grid_step_top dwg_checker u_dwg_checker (.*);

`default_nettype wire
